// ===== hw/rtl/bkpd_pkg.sv =====
// Shared types and constants for the braille keypad packet decoder.
// Used by the decode logic and the top level.
package bkpd_pkg;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_REVERSE_KEYS  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DISPLAY_CELLS = 1'd1;

  localparam logic [7:0] DISPLAY_CELLS_RESET = 8'd40;

  localparam logic [7:0] SHORT_BAR_LEFT  = 8'h83;
  localparam logic [7:0] SHORT_BAR_RIGHT = 8'h80;
  localparam logic [1:0] SHORT_BAR_FLIP  = 2'h3;

  localparam logic [3:0] LONG_BAR_LEFT1  = 4'h8;
  localparam logic [3:0] LONG_BAR_RIGHT1 = 4'h4;
  localparam logic [3:0] LONG_BAR_LEFT2  = 4'h2;
  localparam logic [3:0] LONG_BAR_RIGHT2 = 4'h1;

  localparam logic [2:0] BAR_NONE   = 3'd0;
  localparam logic [2:0] BAR_LEFT   = 3'd1;
  localparam logic [2:0] BAR_RIGHT  = 3'd2;
  localparam logic [2:0] BAR_LEFT1  = 3'd3;
  localparam logic [2:0] BAR_RIGHT1 = 3'd4;
  localparam logic [2:0] BAR_LEFT2  = 3'd5;
  localparam logic [2:0] BAR_RIGHT2 = 3'd6;

  typedef enum logic [1:0] {
    KIND_CHORD = 2'd0,
    KIND_BAR   = 2'd1,
    KIND_ROUTE = 2'd2,
    KIND_OTHER = 2'd3
  } event_kind_e;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_e;

  typedef struct packed {
    logic       reverse_keys;
    logic [7:0] display_cells;
  } bkpd_cfg_t;

  typedef struct packed {
    event_kind_e event_kind;
    logic [7:0]  raw_keys;
    logic        space_bar;
    logic [5:0]  dot_index;
    logic [2:0]  bar_code;
    logic [7:0]  routing_key;
  } bkpd_event_t;

endpackage

// ===== hw/rtl/bkpd_rx_if.sv =====
// Channel interface for received keypad bytes.
// Depends on nothing; one item is one byte.
interface bkpd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ===== hw/rtl/bkpd_evt_if.sv =====
// Channel interface for decoded key events.
// Depends on nothing; one item is one key event.
interface bkpd_evt_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] raw_keys;
  logic       space_bar;
  logic [5:0] dot_index;
  logic [2:0] bar_code;
  logic [7:0] routing_key;

  modport source (output valid, output event_kind, output raw_keys, output space_bar,
                  output dot_index, output bar_code, output routing_key, input ready);
  modport sink (input valid, input event_kind, input raw_keys, input space_bar,
                input dot_index, input bar_code, input routing_key, output ready);
endinterface

// ===== hw/rtl/bkpd_decode.sv =====
// Combinational key event decode for one received byte and the frame state.
// Depends on bkpd_pkg for the configuration and event types.
module bkpd_decode import bkpd_pkg::*; (
  input  phase_e      phase_i,
  input  logic [7:0]  second_byte_i,
  input  logic [7:0]  rx_byte_i,
  input  bkpd_cfg_t   cfg_i,
  output logic        emit_o,
  output bkpd_event_t event_o
);

  logic [7:0] short_c;
  logic [7:0] bar_c;
  logic [7:0] chord_c2;
  logic [7:0] chord_c3;
  logic [7:0] route_num;
  logic [2:0] long_bar;

  always_comb begin
    short_c = rx_byte_i;
    if (cfg_i.reverse_keys) begin
      if (rx_byte_i[7]) begin
        short_c = {rx_byte_i[7:2], rx_byte_i[1:0] ^ SHORT_BAR_FLIP};
      end else begin
        short_c = {1'b0, rx_byte_i[6], rx_byte_i[2:0], rx_byte_i[5:3]};
      end
    end

    bar_c = rx_byte_i;
    chord_c2 = second_byte_i;
    chord_c3 = rx_byte_i;
    route_num = rx_byte_i;
    if (cfg_i.reverse_keys) begin
      bar_c = {rx_byte_i[7:4], rx_byte_i[0], rx_byte_i[1], rx_byte_i[2], rx_byte_i[3]};
      chord_c2 = {second_byte_i[6], second_byte_i[7], second_byte_i[2:0], second_byte_i[5:3]};
      chord_c3 = {1'b0, rx_byte_i[6], rx_byte_i[2:0], rx_byte_i[5:3]};
      route_num = 8'(cfg_i.display_cells - rx_byte_i + 8'd1);
    end

    case (bar_c[3:0])
      LONG_BAR_LEFT1:  long_bar = BAR_LEFT1;
      LONG_BAR_RIGHT1: long_bar = BAR_RIGHT1;
      LONG_BAR_LEFT2:  long_bar = BAR_LEFT2;
      LONG_BAR_RIGHT2: long_bar = BAR_RIGHT2;
      default:         long_bar = BAR_NONE;
    endcase

    emit_o = 1'b0;
    event_o = '0;
    case (phase_i)
      PH_SECOND: begin
        emit_o = 1'b0;
      end
      PH_THIRD: begin
        emit_o = 1'b1;
        if (second_byte_i == 8'd0) begin
          if (rx_byte_i[7]) begin
            event_o.event_kind = (long_bar != BAR_NONE) ? KIND_BAR : KIND_OTHER;
            event_o.raw_keys = bar_c;
            event_o.bar_code = long_bar;
          end else if (rx_byte_i != 8'd0 && rx_byte_i <= cfg_i.display_cells) begin
            event_o.event_kind = KIND_ROUTE;
            event_o.raw_keys = route_num;
            event_o.routing_key = route_num;
          end else begin
            event_o.event_kind = KIND_OTHER;
            event_o.raw_keys = rx_byte_i;
          end
        end else begin
          event_o.event_kind = KIND_CHORD;
          event_o.raw_keys = {chord_c2[7:6], chord_c3[5:0]};
          event_o.space_bar = chord_c3[6];
          event_o.dot_index = chord_c3[5:0];
        end
      end
      default: begin
        emit_o = (rx_byte_i != 8'd0);
        if (short_c[7]) begin
          event_o.raw_keys = short_c;
          if (short_c == SHORT_BAR_LEFT) begin
            event_o.event_kind = KIND_BAR;
            event_o.bar_code = BAR_LEFT;
          end else if (short_c == SHORT_BAR_RIGHT) begin
            event_o.event_kind = KIND_BAR;
            event_o.bar_code = BAR_RIGHT;
          end else begin
            event_o.event_kind = KIND_OTHER;
          end
        end else begin
          event_o.event_kind = KIND_CHORD;
          event_o.raw_keys = {2'b00, short_c[5:0]};
          event_o.space_bar = short_c[6];
          event_o.dot_index = short_c[5:0];
        end
      end
    endcase
  end

endmodule

// ===== hw/rtl/braille_key_packet_decoder_top.sv =====
// Top level of the braille keypad packet decoder: frame state, configuration
// registers and the result register. Uses bkpd_pkg, bkpd_rx_if, bkpd_evt_if
// and bkpd_decode.
// A result is registered and valid in the cycle after the byte that completes its event.
// Throughput: one byte per cycle; ready is high while the result register is empty
// or its item is taken in the same cycle.
// Reset: frame phase idle, result register empty, reverse_keys 0, display_cells 40.
module braille_key_packet_decoder_top import bkpd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  bkpd_rx_if.sink               rx,
  bkpd_evt_if.source            evt
);

  bkpd_cfg_t   cfg_q;
  phase_e      phase_q, phase_d;
  logic [7:0]  second_byte_q;
  logic        out_valid_q;
  bkpd_event_t event_q;
  logic        emit;
  bkpd_event_t event_d;
  logic        in_accept;

  assign rx.ready = !out_valid_q || evt.ready;
  assign in_accept = rx.valid && rx.ready;

  bkpd_decode u_decode (
    .phase_i       (phase_q),
    .second_byte_i (second_byte_q),
    .rx_byte_i     (rx.rx_byte),
    .cfg_i         (cfg_q),
    .emit_o        (emit),
    .event_o       (event_d)
  );

  always_comb begin
    case (phase_q)
      PH_SECOND: phase_d = PH_THIRD;
      PH_THIRD:  phase_d = PH_IDLE;
      default:   phase_d = (rx.rx_byte == 8'd0) ? PH_SECOND : PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reverse_keys <= 1'b0;
      cfg_q.display_cells <= DISPLAY_CELLS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_REVERSE_KEYS:  cfg_q.reverse_keys <= cfg_wdata_i[0];
        REG_DISPLAY_CELLS: cfg_q.display_cells <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        phase_q <= phase_d;
        out_valid_q <= emit;
      end else if (evt.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && phase_q == PH_SECOND) begin
      second_byte_q <= rx.rx_byte;
    end
    if (in_accept && emit) begin
      event_q <= event_d;
    end
  end

  assign evt.valid = out_valid_q;
  assign evt.event_kind = event_q.event_kind;
  assign evt.raw_keys = event_q.raw_keys;
  assign evt.space_bar = event_q.space_bar;
  assign evt.dot_index = event_q.dot_index;
  assign evt.bar_code = event_q.bar_code;
  assign evt.routing_key = event_q.routing_key;

`ifndef SYNTHESIS
  a_second_to_third: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && phase_q == PH_SECOND |=> phase_q == PH_THIRD)
    else $error("Frame phase did not advance after the second byte.");

  a_third_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && phase_q == PH_THIRD |=> out_valid_q)
    else $error("Closing byte of a long frame gave no item.");

  a_route_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q.event_kind == KIND_ROUTE |->
      event_q.routing_key != 8'd0 && event_q.routing_key <= cfg_q.display_cells)
    else $error("Routing key number out of range.");

  a_non_chord_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && event_q.event_kind != KIND_CHORD |->
      !event_q.space_bar && event_q.dot_index == 6'd0)
    else $error("Dot fields set on an item that is no chord.");
`endif

endmodule
